// ----- rtl/core/pulse_beat_detector_unit_defines.svh -----
// Assertion macros for the pulse beat detector RTL, included by pbd_track.
`ifndef PULSE_BEAT_DETECTOR_UNIT_DEFINES_SVH
`define PULSE_BEAT_DETECTOR_UNIT_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define PBD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define PBD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its trigger.
`define PBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/pbd_pkg.sv -----
// Types and constants of the pulse beat detector.
`timescale 1ns / 1ps

package pbd_pkg;

   localparam int SLOPE_W    = 16;
   localparam int INDEX_W    = 16;
   localparam int LEVEL_W    = 24;
   localparam int FLOOR_W    = 15;
   localparam int COEFF_W    = 8;
   localparam int TOTAL_W    = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEVEL_FLOOR   = 3'd0,
      CSR_RISE_COEFF    = 3'd1,
      CSR_FALL_COEFF    = 3'd2,
      CSR_PEAK_POSITION = 3'd3,
      CSR_SILENCE_LIMIT = 3'd4
   } csr_index_type;

   // Reset values
   localparam logic [FLOOR_W-1:0] LEVEL_FLOOR_RST   = 15'd4;
   localparam logic [COEFF_W-1:0] RISE_COEFF_RST    = 8'd179;
   localparam logic [COEFF_W-1:0] FALL_COEFF_RST    = 8'd141;
   localparam logic [INDEX_W-1:0] PEAK_POSITION_RST = 16'd0;
   localparam logic [INDEX_W-1:0] SILENCE_LIMIT_RST = 16'd200;
   localparam logic [INDEX_W-1:0] LOCKOUT_RST       = 16'd50;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX         = 7'd127;

   typedef struct packed {
      logic [FLOOR_W-1:0] level_floor;
      logic [COEFF_W-1:0] rise_coeff;
      logic [COEFF_W-1:0] fall_coeff;
      logic [INDEX_W-1:0] peak_position;
      logic [INDEX_W-1:0] silence_limit;
   } cfg_type;

   typedef struct packed {
      logic                      beat;
      logic signed [INDEX_W-1:0] beat_position;
      logic [TOTAL_W-1:0]        beat_total;
      logic [FLOOR_W-1:0]        threshold;
      logic [FLOOR_W-1:0]        largest_peak;
   } result_type;

endpackage

// ----- rtl/core/pbd_if.sv -----
// Handshake channels of the pulse beat detector: sample words in, result words out.
`timescale 1ns / 1ps

interface pbd_req_if import pbd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SLOPE_W-1:0] slope;
   logic [INDEX_W-1:0]        sample_index;

   modport source (output valid, slope, sample_index, input ready);
   modport sink   (input valid, slope, sample_index, output ready);
endinterface

interface pbd_rsp_if import pbd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      beat;
   logic signed [INDEX_W-1:0] beat_position;
   logic [TOTAL_W-1:0]        beat_total;
   logic [FLOOR_W-1:0]        threshold;
   logic [FLOOR_W-1:0]        largest_peak;

   modport source (output valid, beat, beat_position, beat_total, threshold, largest_peak,
                   input ready);
   modport sink   (input valid, beat, beat_position, beat_total, threshold, largest_peak,
                   output ready);
endinterface

// ----- rtl/core/pbd_csr.sv -----
// Configuration registers of the pulse beat detector.
`timescale 1ns / 1ps

module pbd_csr import pbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   // Load the addressed register, drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_floor   <= LEVEL_FLOOR_RST;
         cfg_ff.rise_coeff    <= RISE_COEFF_RST;
         cfg_ff.fall_coeff    <= FALL_COEFF_RST;
         cfg_ff.peak_position <= PEAK_POSITION_RST;
         cfg_ff.silence_limit <= SILENCE_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LEVEL_FLOOR:   cfg_ff.level_floor   <= csr_wdata[FLOOR_W-1:0];
            CSR_RISE_COEFF:    cfg_ff.rise_coeff    <= csr_wdata[COEFF_W-1:0];
            CSR_FALL_COEFF:    cfg_ff.fall_coeff    <= csr_wdata[COEFF_W-1:0];
            CSR_PEAK_POSITION: cfg_ff.peak_position <= csr_wdata[INDEX_W-1:0];
            CSR_SILENCE_LIMIT: cfg_ff.silence_limit <= csr_wdata[INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/pbd_store.sv -----
// Beat position store: one synchronous write port.
`timescale 1ns / 1ps

module pbd_store import pbd_pkg::*; #(
   parameter  int BEAT_SLOTS = 64,
   localparam int ADDR_W     = $clog2(BEAT_SLOTS)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [INDEX_W-1:0] wr_data
);

   logic [INDEX_W-1:0] mem [BEAT_SLOTS];

   // Write one beat position a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

// ----- rtl/core/pbd_track.sv -----
// Detector state and per-sample arm, peak and beat decisions.
`timescale 1ns / 1ps
`include "pulse_beat_detector_unit_defines.svh"

module pbd_track import pbd_pkg::*; #(
   parameter  int BEAT_SLOTS = 64,
   localparam int CNT_W      = $clog2(BEAT_SLOTS + 1),
   localparam int ADDR_W     = $clog2(BEAT_SLOTS)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic signed [SLOPE_W-1:0] slope,
   input  logic [INDEX_W-1:0]        sample_index,
   input  cfg_type                   cfg,
   output result_type                result,
   output logic                      store_we,
   output logic [ADDR_W-1:0]         store_addr,
   output logic [INDEX_W-1:0]        store_data
);

   logic [LEVEL_W-1:0]        level_ff, level_in;
   logic signed [SLOPE_W-1:0] run_peak_ff, run_peak_in;
   logic [INDEX_W-1:0]        run_idx_ff, run_idx_in;
   logic signed [SLOPE_W-1:0] top_peak_ff, top_peak_in;
   logic                      armed_ff, armed_in;
   logic signed [INDEX_W-1:0] quiet_ff, quiet_in;
   logic signed [INDEX_W-1:0] lockout_ff, lockout_in;
   logic signed [INDEX_W-1:0] last_ff, last_in;
   logic signed [INDEX_W-1:0] prior_ff, prior_in;
   logic [INDEX_W-1:0]        idle_ff, idle_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   logic [LEVEL_W-1:0]        floor_q8;
   logic [INDEX_W-1:0]        idle_inc;
   logic [LEVEL_W-1:0]        level_base;
   logic signed [INDEX_W:0]   pos;
   logic signed [INDEX_W:0]   gate_lim;
   logic                      gate;
   logic signed [LEVEL_W:0]   slope_q8;
   logic signed [LEVEL_W:0]   level_cmp;
   logic                      above, below;
   logic                      active, new_peak, beat;
   logic [INDEX_W-1:0]        rec;
   logic signed [INDEX_W:0]   diff;
   logic signed [INDEX_W:0]   diff_adj;
   logic signed [INDEX_W:0]   half;
   logic [COEFF_W-1:0]        coeff;
   logic [LEVEL_W-1:0]        prod;
   logic                      store_free;
   logic [31:0]               total_wide;

   // Age the silence counter and fall back to the floor after a long gap
   assign floor_q8   = {1'b0, cfg.level_floor, 8'd0};
   assign idle_inc   = (idle_ff != '1) ? idle_ff + 16'd1 : idle_ff;
   assign level_base = (idle_inc > cfg.silence_limit) ? floor_q8 : level_ff;

   // Lockout gate on the signed sample position
   assign pos      = $signed({1'b0, sample_index}) - 17'sd1;
   assign gate_lim = {quiet_ff[INDEX_W-1], quiet_ff} + {lockout_ff[INDEX_W-1], lockout_ff};
   assign gate     = pos > gate_lim;

   // Compare slope against the Q.8 threshold
   assign slope_q8  = {slope[SLOPE_W-1], slope, 8'd0};
   assign level_cmp = $signed({1'b0, level_base});
   assign above     = slope_q8 > level_cmp;
   assign below     = slope_q8 < level_cmp;

   assign active   = (armed_ff | (above & gate)) & gate;
   assign new_peak = active & (slope > run_peak_ff);
   assign beat     = active & ~new_peak & below;

   // Beat bookkeeping: recorded position, half interval, next threshold
   assign rec      = run_idx_ff - 16'd1;
   assign diff     = {rec[INDEX_W-1], rec} - {last_ff[INDEX_W-1], last_ff};
   assign diff_adj = diff + $signed({{INDEX_W{1'b0}}, diff[INDEX_W]});
   assign half     = diff_adj >>> 1;
   assign coeff    = (sample_index < cfg.peak_position) ? cfg.rise_coeff : cfg.fall_coeff;
   assign prod     = {8'd0, $unsigned(run_peak_ff)} * {16'd0, coeff};

   assign store_free = count_ff < CNT_W'(BEAT_SLOTS);

   // Next state
   always_comb begin
      level_in    = level_base;
      run_peak_in = run_peak_ff;
      run_idx_in  = run_idx_ff;
      top_peak_in = top_peak_ff;
      armed_in    = armed_ff | (above & gate);
      quiet_in    = quiet_ff;
      lockout_in  = lockout_ff;
      last_in     = last_ff;
      prior_in    = prior_ff;
      idle_in     = idle_inc;
      count_in    = count_ff;
      if (new_peak) begin
         run_peak_in = slope;
         run_idx_in  = pos[INDEX_W-1:0];
      end else if (beat) begin
         if (run_peak_ff > top_peak_ff) begin
            top_peak_in = run_peak_ff;
         end
         prior_in   = last_ff;
         last_in    = $signed(rec);
         quiet_in   = $signed(rec);
         lockout_in = half[INDEX_W-1:0];
         level_in   = (prod < floor_q8) ? floor_q8 : prod;
         if (store_free) begin
            count_in = count_ff + CNT_W'(1);
         end
         run_peak_in = '0;
         idle_in     = '0;
         armed_in    = 1'b0;
      end
   end

   // Hold state between accepted sample words
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= {1'b0, LEVEL_FLOOR_RST, 8'd0};
         run_peak_ff <= '0;
         run_idx_ff  <= '0;
         top_peak_ff <= '0;
         armed_ff    <= 1'b0;
         quiet_ff    <= '0;
         lockout_ff  <= $signed(LOCKOUT_RST);
         last_ff     <= '0;
         prior_ff    <= '0;
         idle_ff     <= '0;
         count_ff    <= '0;
      end else if (step) begin
         level_ff    <= level_in;
         run_peak_ff <= run_peak_in;
         run_idx_ff  <= run_idx_in;
         top_peak_ff <= top_peak_in;
         armed_ff    <= armed_in;
         quiet_ff    <= quiet_in;
         lockout_ff  <= lockout_in;
         last_ff     <= last_in;
         prior_ff    <= prior_in;
         idle_ff     <= idle_in;
         count_ff    <= count_in;
      end
   end

   // Store write for a beat while room is left
   assign store_we   = step & beat & store_free;
   assign store_addr = count_ff[ADDR_W-1:0];
   assign store_data = rec;

   // Result word
   assign total_wide           = 32'(count_in);
   assign result.beat          = beat;
   assign result.beat_position = beat ? $signed(rec) : '0;
   assign result.beat_total    = (total_wide > 32'(TOTAL_MAX)) ? TOTAL_MAX
                                                               : total_wide[TOTAL_W-1:0];
   assign result.threshold     = level_in[LEVEL_W-2:8];
   assign result.largest_peak  = top_peak_in[FLOOR_W-1:0];

   `PBD_ASSERT_ALWAYS(count_bounded_a, count_ff <= CNT_W'(BEAT_SLOTS), "beat count past store size")
   `PBD_ASSERT_NEXT(beat_clears_a, step && result.beat, !armed_ff && run_peak_ff == 16'sd0 && idle_ff == 16'd0, "beat did not clear tracking state")
   `PBD_ASSERT_IMPLY(store_on_beat_a, store_we, step && result.beat, "store write without a beat")

endmodule

// ----- rtl/core/pulse_beat_detector_unit.sv -----
// Top level of the pulse beat detector: channels, configuration and result register.
//
// Usage:
//   req_chan carries one slope sample and its sample index per word; rsp_chan
//   returns exactly one result word per sample (beat flag, beat position,
//   stored beat total, current threshold and largest peak).
//   csr_we/csr_index/csr_wdata write one configuration register per cycle;
//   write only while no sample word is in flight.
// Timing and throughput:
//   A result word appears in the cycle after its sample word is taken. One
//   sample word is taken per cycle outside a stall; the detector state
//   updates in one pass per word and beat positions go to a one-port store.
// Reset (synchronous, active high):
//   Clears the detector state, loads the register defaults and empties the
//   result register. The beat store contents stay undefined until written.
// Stall:
//   While a result word waits with rsp_chan.ready low, req_chan.ready drops;
//   the input side opens again in the cycle the result word is taken.
`timescale 1ns / 1ps

module pulse_beat_detector_unit import pbd_pkg::*; #(
   parameter int BEAT_SLOTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   pbd_req_if.sink               req_chan,
   pbd_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(BEAT_SLOTS);

   cfg_type            cfg;
   result_type         result;
   result_type         rsp_word_ff;
   logic               rsp_valid_ff;
   logic               step;
   logic               store_we;
   logic [ADDR_W-1:0]  store_addr;
   logic [INDEX_W-1:0] store_data;

   pbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pbd_track #(.BEAT_SLOTS(BEAT_SLOTS)) u_track (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .slope        (req_chan.slope),
      .sample_index (req_chan.sample_index),
      .cfg          (cfg),
      .result       (result),
      .store_we     (store_we),
      .store_addr   (store_addr),
      .store_data   (store_data)
   );

   pbd_store #(.BEAT_SLOTS(BEAT_SLOTS)) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_addr),
      .wr_data (store_data)
   );

   // Take a sample word whenever the result register is empty or draining
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign step           = req_chan.valid & req_chan.ready;

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.beat          = rsp_word_ff.beat;
   assign rsp_chan.beat_position = rsp_word_ff.beat_position;
   assign rsp_chan.beat_total    = rsp_word_ff.beat_total;
   assign rsp_chan.threshold     = rsp_word_ff.threshold;
   assign rsp_chan.largest_peak  = rsp_word_ff.largest_peak;

endmodule

// ----- tb/pulse_beat_detector_unit_tb.sv -----
// Testbench of the pulse beat detector: random pulse trains, predictor and scoreboard.
`timescale 1ns / 1ps

module pulse_beat_detector_unit_tb;
   import pbd_pkg::*;

   localparam int BEAT_SLOTS  = 64;
   localparam int CYCLE_LIMIT = 500_000;

   typedef struct {
      logic signed [SLOPE_W-1:0] slope;
      logic [INDEX_W-1:0]        sample_index;
   } sample_word_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pbd_req_if req_chan ();
   pbd_rsp_if rsp_chan ();

   pulse_beat_detector_unit #(.BEAT_SLOTS(BEAT_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Stimulus and scoreboard bookkeeping
   sample_word_type    pending[$];
   result_type         beat_expect[$];
   int                 queued_total = 0;
   int                 words_taken  = 0;
   int                 fail_count   = 0;
   int                 cycle_count  = 0;
   logic [INDEX_W-1:0] next_index   = '0;
   bit                 idle_on      = 1'b1;
   bit                 stall_req    = 1'b0;

   // Detector copy: settings and state
   cfg_type            model_cfg;
   logic [LEVEL_W-1:0] lvl_q8;
   int                 pk_slope;
   logic [INDEX_W-1:0] pk_index;
   int                 top_slope;
   bit                 armed_now;
   int                 quiet_pos;
   int                 lock_len;
   int                 last_pos;
   int                 prior_pos;
   int                 idle_run;
   int                 stored_beats;

   // Advance the detector copy by one sample word and return the result word it yields
   function automatic result_type detect_step(logic signed [SLOPE_W-1:0] slope,
                                              logic [INDEX_W-1:0] index);
      result_type         r;
      int                 s;
      int                 pos;
      int                 half;
      longint             s_q8;
      bit                 gate;
      logic [INDEX_W-1:0] rec;
      logic [COEFF_W-1:0] coeff;
      s    = int'(slope);
      pos  = int'(index) - 1;
      s_q8 = longint'(s) * 256;
      r    = '0;

      // silence check comes before arming
      if (idle_run < 65535) idle_run++;
      if (idle_run > int'(model_cfg.silence_limit)) lvl_q8 = {1'b0, model_cfg.level_floor, 8'h00};

      gate = pos > quiet_pos + lock_len;
      if (s_q8 > longint'(lvl_q8) && gate) armed_now = 1'b1;

      if (armed_now && gate) begin
         if (s > pk_slope) begin
            pk_slope = s;
            pk_index = pos[INDEX_W-1:0];
         end else if (s_q8 < longint'(lvl_q8)) begin
            // on a beat: record peak, set lockout to half the interval, rescale threshold
            rec = pk_index - 16'd1;
            if (pk_slope > top_slope) top_slope = pk_slope;
            prior_pos = last_pos;
            last_pos  = int'($signed(rec));
            if (stored_beats < BEAT_SLOTS) stored_beats++;
            half      = (last_pos - prior_pos) / 2;
            lock_len  = int'($signed(half[15:0]));
            quiet_pos = last_pos;
            coeff     = (index < model_cfg.peak_position) ? model_cfg.rise_coeff
                                                          : model_cfg.fall_coeff;
            lvl_q8    = LEVEL_W'(pk_slope * int'(coeff));
            if (lvl_q8 < {1'b0, model_cfg.level_floor, 8'h00}) begin
               lvl_q8 = {1'b0, model_cfg.level_floor, 8'h00};
            end
            pk_slope  = 0;
            idle_run  = 0;
            armed_now = 1'b0;
            r.beat          = 1'b1;
            r.beat_position = rec;
         end
      end

      r.beat_total   = (stored_beats > int'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(stored_beats);
      r.threshold    = lvl_q8[22:8];
      r.largest_peak = top_slope[FLOOR_W-1:0];
      return r;
   endfunction

   function automatic void add_sample(logic signed [SLOPE_W-1:0] slope_v,
                                      logic [INDEX_W-1:0] index_v);
      sample_word_type w;
      w.slope        = slope_v;
      w.sample_index = index_v;
      pending.push_back(w);
      queued_total++;
   endfunction

   function automatic logic [INDEX_W-1:0] take_index();
      logic [INDEX_W-1:0] idx;
      idx        = next_index;
      next_index = next_index + 16'd1;
      return idx;
   endfunction

   // Queue one pulse: quiet baseline, rising ramp, and a drop below threshold when complete
   task automatic add_pulse(input bit complete);
      int base_len;
      int rise_len;
      int amp;
      base_len = $urandom_range(2, 6);
      rise_len = $urandom_range(1, 3);
      amp      = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4000)
                                             : $urandom_range(4000, 32767);
      repeat (base_len) add_sample(SLOPE_W'(-int'($urandom_range(0, 500))), take_index());
      for (int i = 1; i <= rise_len; i++) add_sample(SLOPE_W'(amp * i / rise_len), take_index());
      if (complete) add_sample(SLOPE_W'(-int'($urandom_range(0, 2000))), take_index());
   endtask

   // Wait until every queued word has come back, plus a short margin
   task automatic settle();
      while (words_taken != queued_total || beat_expect.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type which, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      case (which)
         CSR_LEVEL_FLOOR:   model_cfg.level_floor   = value[FLOOR_W-1:0];
         CSR_RISE_COEFF:    model_cfg.rise_coeff    = value[COEFF_W-1:0];
         CSR_FALL_COEFF:    model_cfg.fall_coeff    = value[COEFF_W-1:0];
         CSR_PEAK_POSITION: model_cfg.peak_position = value;
         CSR_SILENCE_LIMIT: model_cfg.silence_limit = value;
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [FLOOR_W-1:0] floor_v,
                                input logic [COEFF_W-1:0] rise_v, fall_v,
                                input logic [INDEX_W-1:0] peak_v, silence_v);
      write_reg(CSR_LEVEL_FLOOR, CSR_DATA_W'(floor_v));
      write_reg(CSR_RISE_COEFF, CSR_DATA_W'(rise_v));
      write_reg(CSR_FALL_COEFF, CSR_DATA_W'(fall_v));
      write_reg(CSR_PEAK_POSITION, peak_v);
      write_reg(CSR_SILENCE_LIMIT, silence_v);
      @(posedge clock) csr_we <= 1'b0;
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Drive sample words from the pending queue, with random gaps
   int send_gap = 0;
   always @(posedge clock) begin : drive_samples
      sample_word_type w;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (send_gap > 0) begin
            req_chan.valid <= 1'b0;
            send_gap       <= send_gap - 1;
         end else if (pending.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            req_chan.valid <= 1'b0;
            send_gap       <= $urandom_range(0, 16);
         end else begin
            w = pending.pop_front();
            req_chan.valid        <= 1'b1;
            req_chan.slope        <= w.slope;
            req_chan.sample_index <= w.sample_index;
         end
      end
   end

   // Drive result ready: random stalls and one long hold-off
   int  recv_gap  = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_gap       <= 0;
         hold_left      <= 0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (stall_req && !hold_done) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 400;
         hold_done      <= 1'b1;
      end else if (recv_gap > 0) begin
         rsp_chan.ready <= 1'b0;
         recv_gap       <= recv_gap - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         recv_gap       <= $urandom_range(0, 16);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Check result words against the oldest prediction, then predict taken sample words
   always @(posedge clock) begin : score
      result_type want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (beat_expect.size() == 0) begin
               $error("result word with no sample word outstanding");
               fail_count++;
            end else begin
               want = beat_expect.pop_front();
               if (rsp_chan.beat !== want.beat) begin
                  $error("beat: expected %0d, got %0d", want.beat, rsp_chan.beat);
                  fail_count++;
               end
               if (rsp_chan.beat_position !== want.beat_position) begin
                  $error("beat_position: expected %0d, got %0d",
                         want.beat_position, rsp_chan.beat_position);
                  fail_count++;
               end
               if (rsp_chan.beat_total !== want.beat_total) begin
                  $error("beat_total: expected %0d, got %0d",
                         want.beat_total, rsp_chan.beat_total);
                  fail_count++;
               end
               if (rsp_chan.threshold !== want.threshold) begin
                  $error("threshold: expected %0d, got %0d",
                         want.threshold, rsp_chan.threshold);
                  fail_count++;
               end
               if (rsp_chan.largest_peak !== want.largest_peak) begin
                  $error("largest_peak: expected %0d, got %0d",
                         want.largest_peak, rsp_chan.largest_peak);
                  fail_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            beat_expect.push_back(detect_step(req_chan.slope, req_chan.sample_index));
            words_taken++;
         end
      end
   end

   // Drop the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int pick;
      int phase_start;

      // known levels from time zero
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_LEVEL_FLOOR;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.slope        = '0;
      req_chan.sample_index = '0;
      rsp_chan.ready        = 1'b0;

      // detector copy after reset
      model_cfg.level_floor   = LEVEL_FLOOR_RST;
      model_cfg.rise_coeff    = RISE_COEFF_RST;
      model_cfg.fall_coeff    = FALL_COEFF_RST;
      model_cfg.peak_position = PEAK_POSITION_RST;
      model_cfg.silence_limit = SILENCE_LIMIT_RST;
      lvl_q8       = {1'b0, LEVEL_FLOOR_RST, 8'h00};
      pk_slope     = 0;
      pk_index     = '0;
      top_slope    = 0;
      armed_now    = 1'b0;
      quiet_pos    = 0;
      lock_len     = int'(LOCKOUT_RST);
      last_pos     = 0;
      prior_pos    = 0;
      idle_run     = 0;
      stored_beats = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words at reset settings: lockout edge, index wrap, odd and wide intervals
      add_sample(16'sh7FFF, 16'd0);       // position -1, gated
      add_sample(16'sh8000, 16'hFFFF);
      add_sample(16'sd0, 16'd51);         // position equals lockout end, still gated
      add_sample(16'sd5, 16'd52);         // arm just over the floor
      add_sample(16'sh7FFF, 16'd53);
      add_sample(16'sh7FFF, 16'd54);      // equal to peak, no beat
      add_sample(16'sd3, 16'd55);         // beat
      add_sample(16'sh7FFF, 16'd60);      // inside lockout
      add_sample(16'sh7FFF, 16'hFFFF);
      add_sample(16'sh8000, 16'hFFFF);    // beat, negative interval
      add_sample(16'sh7FFF, 16'd0);
      add_sample(16'sd0, 16'd0);          // beat at a wrapped position
      add_sample(16'sh7FFF, 16'd1);
      add_sample(-16'sd1, 16'd2);
      add_sample(16'sh7FFF, 16'd32769);
      add_sample(16'sh8000, 16'd32769);   // beat at the top positive position
      add_sample(16'sh7FFF, 16'd50000);
      add_sample(16'sd0, 16'd50001);      // wide negative interval, odd halving
      repeat (4) add_sample(SLOPE_W'($urandom), INDEX_W'($urandom));
      settle();

      // Register extremes: zero floor with silence reset every word
      load_settings(15'd0, 8'd255, 8'd0, 16'hFFFF, 16'd0);
      next_index = INDEX_W'($urandom);
      repeat (3) add_pulse(1'b1);
      repeat (2) add_sample(SLOPE_W'($urandom), INDEX_W'($urandom));
      settle();

      // Top floor: level holds until the next beat, then clamps
      load_settings(15'h7FFF, 8'd0, 8'd255, 16'd0, 16'hFFFF);
      repeat (3) add_pulse(1'b1);
      settle();

      load_settings(15'd2, 8'd0, 8'd255, 16'hFFFF, 16'd1);
      repeat (3) add_pulse(1'b1);
      settle();

      // Random phases; hold off the receiver early on to fill the block
      stall_req = 1'b1;
      repeat (4) begin
         load_settings(FLOOR_W'($urandom_range(0, 300)), COEFF_W'($urandom_range(90, 230)),
                       COEFF_W'($urandom_range(60, 200)), INDEX_W'($urandom),
                       INDEX_W'($urandom_range(10, 400)));
         phase_start = queued_total;
         while (queued_total - phase_start < 45) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) add_pulse(1'b1);
            else if (pick < 17) add_pulse(1'b0);
            else if (pick < 18) next_index = INDEX_W'($urandom);
            else add_sample(SLOPE_W'($urandom), INDEX_W'($urandom));
         end
         settle();
      end

      // Last part without idling: a long quiet run, then a lower silence limit
      idle_on = 1'b0;
      load_settings(15'd1, 8'd179, 8'd141, 16'd32768, 16'hFFFF);
      repeat (12) add_pulse(1'b1);
      repeat (110) add_sample(SLOPE_W'(-int'($urandom_range(0, 32768))), take_index());
      settle();
      load_settings(15'd1, 8'd179, 8'd141, 16'd32768, 16'd100);
      repeat (8) add_pulse(1'b1);
      repeat (5) add_sample(SLOPE_W'($urandom), INDEX_W'($urandom));
      settle();

      repeat (4) @(posedge clock);
      if (fail_count == 0 && beat_expect.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/pbd_pkg.sv
rtl/core/pbd_if.sv
rtl/core/pbd_csr.sv
rtl/core/pbd_store.sv
rtl/core/pbd_track.sv
rtl/core/pulse_beat_detector_unit.sv
tb/pulse_beat_detector_unit_tb.sv
